>>> src/osp_pkg.sv
// Shared types, constants and codes for the oil sensor pulse-width frame decoder.
package osp_pkg;

  // Timestamp arithmetic width; differences wrap modulo 2^TimestampBits.
  localparam int TimestampBits = 32;
  typedef logic [TimestampBits-1:0] stamp_t;

  localparam int CfgBits     = 11;  // level calibration registers
  localparam int ValueBits   = 12;  // signed result in tenths
  localparam int DeltaBits   = 17;  // clamped width minus 22 ms, up to 66000
  localparam int SpanBits    = 11;  // magnitude of the endpoint difference
  localparam int ProductBits = 28;  // |span| * delta, plus the rounding half
  localparam int QuotBits    = 11;  // rounded offset, at most 2047

  // Divide by 66000 = 16 * 4125: shift by four, then multiply by the
  // rounded-up reciprocal of 4125 and keep the bits above the post shift.
  localparam int DivShift     = 4;
  localparam int DividendBits = ProductBits - DivShift;
  localparam int RecipBits    = 25;
  localparam int RecipProdBits = DividendBits + RecipBits;
  localparam int DivPostShift = 37;
  localparam logic [RecipBits-1:0] DivRecip = 25'd33318535;
  localparam logic [ProductBits-1:0] HalfSpan = 28'd33000;

  // Gap windows (exclusive bounds), width reject and clamp limits in us.
  localparam stamp_t LongGapLo     = stamp_t'(694200);
  localparam stamp_t LongGapHi     = stamp_t'(865800);
  localparam stamp_t ShortGapLo    = stamp_t'(97900);
  localparam stamp_t ShortGapHi    = stamp_t'(122100);
  localparam stamp_t WidthRejectLo = stamp_t'(20000);
  localparam stamp_t WidthRejectHi = stamp_t'(100000);
  localparam stamp_t WidthClampLo  = stamp_t'(22000);
  localparam stamp_t WidthClampHi  = stamp_t'(88000);

  // Temperature endpoints in tenths of a degree.
  localparam logic signed [ValueBits-1:0] TempLoTenths = -12'sd400;
  localparam logic [SpanBits-1:0]         TempSpan     = 11'd2000;

  localparam logic [CfgBits-1:0] LevelMinReset = 11'd209;
  localparam logic [CfgBits-1:0] LevelMaxReset = 11'd659;

  // Slot codes.
  localparam logic [1:0] SlotNone  = 2'd0;
  localparam logic [1:0] SlotTemp  = 2'd1;
  localparam logic [1:0] SlotLevel = 2'd2;
  localparam logic [1:0] SlotDiag  = 2'd3;

  // Configuration register indexes.
  localparam logic CfgLevelAtMin = 1'b0;
  localparam logic CfgLevelAtMax = 1'b1;

  // Measurement kinds.
  localparam logic KindTemp  = 1'b0;
  localparam logic KindLevel = 1'b1;

  typedef struct packed {
    logic [31:0] edge_time;
    logic        pin_level;
  } in_word_t;

  typedef struct packed {
    logic                        measurement_kind;
    logic signed [ValueBits-1:0] measurement_value;
    logic [31:0]                 measured_at;
  } out_word_t;

endpackage

>>> src/oil_sensor_pwm_frame_decoder_unit.sv
// Top level of the oil sensor pulse-width frame decoder.
// A word moves through the input, product and result registers in order before its result shows at out_valid_o.
// Throughput: one edge word per cycle; the stage that reads and writes the slot
// state handles one word per cycle, and each stage holds when the one after it is full.
// Reset: slot none, no rise seen, last rise time zero, calibration 209 and 659
// tenths of a mm, all pipeline stages empty.
module oil_sensor_pwm_frame_decoder_unit
  import osp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CfgBits-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o
);

  // Calibration registers.
  logic [CfgBits-1:0] level_min_q, level_max_q;

  // Decoder state.
  logic [1:0] slot_q, slot_d;
  stamp_t     last_rise_q;
  logic       rise_seen_q;

  // Stage 0: input register.
  logic     in_valid_q;
  in_word_t in_q;

  // Stage 1: product register.
  logic                        mul_valid_q;
  logic [ProductBits-1:0]      mag_q, mag_d;
  logic                        neg_q, neg_d;
  logic signed [ValueBits-1:0] base_q, base_d;
  logic                        kind_q, kind_d;
  logic [31:0]                 time_q;

  // Stage 2: result register.
  logic      out_valid_q;
  out_word_t out_q;

  logic                        out_free, mul_ready, take_in, proc, emit;
  stamp_t                      elapsed, width;
  logic [DeltaBits-1:0]        delta;
  logic signed [ValueBits:0]   span;
  logic [SpanBits-1:0]         span_mag;
  logic signed [ValueBits-1:0] value;

  // Each stage moves on when the next one is empty or moving on itself.
  assign out_free   = !out_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || out_free;
  assign in_ready_o = !in_valid_q || mul_ready;
  assign take_in    = in_valid_i && in_ready_o;
  assign proc       = in_valid_q && mul_ready;

  // Classify the word against the state; decide slot and whether a result follows.
  always_comb begin
    elapsed  = stamp_t'(in_q.edge_time) - last_rise_q;
    slot_d   = slot_q;
    emit     = 1'b0;
    width    = elapsed;
    kind_d   = KindTemp;
    base_d   = TempLoTenths;
    span     = $signed({2'b00, TempSpan});
    if (in_q.pin_level) begin
      // Rising edge: long gap syncs, short gap advances, anything else drops sync.
      if (!rise_seen_q) begin
        slot_d = SlotNone;
      end else if (elapsed > LongGapLo && elapsed < LongGapHi) begin
        slot_d = SlotTemp;
      end else if (elapsed > ShortGapLo && elapsed < ShortGapHi) begin
        unique case (slot_q)
          SlotTemp:  slot_d = SlotLevel;
          SlotLevel: slot_d = SlotDiag;
          default:   slot_d = SlotNone;
        endcase
      end else begin
        slot_d = SlotNone;
      end
    end else begin
      // Falling edge: reject implausible widths, otherwise measure in temp/level slots.
      if (!rise_seen_q || elapsed > WidthRejectHi || elapsed < WidthRejectLo) begin
        slot_d = SlotNone;
      end else begin
        emit = (slot_q == SlotTemp) || (slot_q == SlotLevel);
        if (slot_q == SlotLevel) begin
          kind_d = KindLevel;
          base_d = $signed({1'b0, level_min_q});
          span   = $signed({2'b00, level_max_q}) - $signed({2'b00, level_min_q});
        end
      end
    end
    // Clamp width to the calibrated range.
    priority if (elapsed < WidthClampLo) begin
      width = WidthClampLo;
    end else if (elapsed > WidthClampHi) begin
      width = WidthClampHi;
    end else begin
      width = elapsed;
    end
    delta    = DeltaBits'(width - WidthClampLo);
    // Multiply the magnitude; carry the sign alongside for the rounding stage.
    neg_d    = span[ValueBits];
    span_mag = neg_d ? SpanBits'(-span) : SpanBits'(span);
    mag_d    = {{(ProductBits-SpanBits){1'b0}}, span_mag}
             * {{(ProductBits-DeltaBits){1'b0}}, delta};
  end

  osp_span_div u_span_div (
    .mag_i   (mag_q),
    .neg_i   (neg_q),
    .base_i  (base_q),
    .value_o (value)
  );

  // Calibration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_min_q <= LevelMinReset;
      level_max_q <= LevelMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLevelAtMin: level_min_q <= cfg_data_i;
        CfgLevelAtMax: level_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slot state, advanced once per word leaving the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SlotNone;
      last_rise_q <= '0;
      rise_seen_q <= 1'b0;
    end else if (proc) begin
      slot_q <= slot_d;
      if (in_q.pin_level) begin
        last_rise_q <= stamp_t'(in_q.edge_time);
        rise_seen_q <= 1'b1;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (mul_ready) begin
        mul_valid_q <= proc && emit;
      end
      if (out_free) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  // Pipeline payload: load only on a move, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_word_i;
    end
    if (proc && emit) begin
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      base_q <= base_d;
      kind_q <= kind_d;
      time_q <= in_q.edge_time;
    end
    if (mul_valid_q && out_free) begin
      out_q.measurement_kind  <= kind_q;
      out_q.measurement_value <= value;
      out_q.measured_at       <= time_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> src/osp_span_div.sv
// Rounded divide of the interpolation product by 66000 and add of the base value.
module osp_span_div
  import osp_pkg::*;
(
  input  logic [ProductBits-1:0]        mag_i,
  input  logic                          neg_i,
  input  logic signed [ValueBits-1:0]   base_i,
  output logic signed [ValueBits-1:0]   value_o
);

  logic [ProductBits-1:0]        biased;
  logic [DividendBits-1:0]       dividend;
  logic [RecipProdBits-1:0]      recip_prod;
  logic [QuotBits-1:0]           quot;
  logic signed [ValueBits:0]     offset;
  logic signed [ValueBits:0]     sum;

  always_comb begin
    biased     = mag_i + HalfSpan;
    dividend   = biased[ProductBits-1:DivShift];
    recip_prod = {{RecipBits{1'b0}}, dividend} * {{DividendBits{1'b0}}, DivRecip};
    quot       = recip_prod[DivPostShift+QuotBits-1:DivPostShift];
    offset     = neg_i ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    sum        = {base_i[ValueBits-1], base_i} + offset;
    value_o    = sum[ValueBits-1:0];
  end

endmodule
